FILE: sv/hrlp_pkg.sv
package hrlp_pkg;

    localparam int unsigned LINE_MAX      = 4095;
    localparam int unsigned VERSION_BYTES = 8;
    localparam int unsigned LEN_W         = 12;
    localparam int unsigned VPOS_W        = 4;

    localparam logic [LEN_W:0] LINE_CAP =
        (LINE_MAX > 4095) ? 13'd4095 : (LEN_W + 1)'(LINE_MAX);

    localparam logic [LEN_W-1:0] MAX_LINE_LEN_RESET = 12'd4095;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;

    localparam logic [VPOS_W-1:0] VPOS_MAJOR = 4'd5;
    localparam logic [VPOS_W-1:0] VPOS_MINOR = 4'd7;
    localparam logic [VPOS_W-1:0] VPOS_END   = 4'(VERSION_BYTES);

    localparam logic [1:0] ESC_IDLE   = 2'd0;
    localparam logic [1:0] ESC_FIRST  = 2'd1;
    localparam logic [1:0] ESC_SECOND = 2'd2;

    typedef logic [7:0] ver_pattern_t [VERSION_BYTES];

    localparam ver_pattern_t VER_PATTERN = '{
        8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h30, 8'h2E, 8'h30
    };

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_METHOD  = 4'd1,
        PH_TSTART  = 4'd2,
        PH_PATH    = 4'd3,
        PH_QUERY   = 4'd4,
        PH_VERSION = 4'd5,
        PH_CR      = 4'd6,
        PH_LF      = 4'd7,
        PH_DONE    = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_METHOD     = 3'd1,
        ERR_TARGET     = 3'd2,
        ERR_SEPARATOR  = 3'd3,
        ERR_VERSION    = 3'd4,
        ERR_TERMINATOR = 3'd5,
        ERR_LENGTH     = 3'd6
    } err_code_t;

    typedef struct packed {
        logic tchar;
        logic pchar;
        logic hex;
        logic digit;
    } char_class_t;

    typedef struct packed {
        logic             ok;
        err_code_t        err;
        logic [LEN_W-1:0] method_len;
        logic [LEN_W-1:0] path_bytes;
        logic [LEN_W-1:0] query_bytes;
        logic             query_present;
        logic [3:0]       major;
        logic [3:0]       minor;
        logic [LEN_W-1:0] line_len;
    } result_t;

endpackage

FILE: sv/hrlp_char_class.sv
module hrlp_char_class
(
    input  logic [7:0]           char_in,
    output hrlp_pkg::char_class_t cls
);

    import hrlp_pkg::*;

    logic alnum;

    always_comb
    begin
        alnum = char_in inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};

        cls.digit = char_in inside {[8'h30:8'h39]};
        cls.hex   = char_in inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
        cls.tchar = alnum || (char_in inside {
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
            8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E});
        cls.pchar = alnum || (char_in inside {
            8'h2D, 8'h2E, 8'h5F, 8'h7E, 8'h21, 8'h24, 8'h26, 8'h27,
            8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D, 8'h3A, 8'h40});
    end

endmodule

FILE: sv/http_request_line_parser_core.sv
// Checks an HTTP request line fed one byte per transfer on the input
// channel (data_byte, first_byte, end_of_data). A byte with first_byte set
// starts a new line and drops any line in progress; other bytes that arrive
// with no line open are dropped silently. Each line gives at most one
// result on the output channel, none if it is dropped: on the LF of a valid
// line, at the first bad byte, when the line exceeds max_line_len, or on
// end_of_data before the line is complete.
// The block takes one byte per clock cycle while in_ready is high. A result
// is registered before it is presented on out_valid.
// The configuration channel writes max_line_len; cfg_ready is always high.
// The user must make writes only while the parser is idle; the block does not enforce it.
// Reset closes any open line, empties the output stage and sets
// max_line_len to 4095.
// When the receiver stalls, one result waits in the output register and a
// second one in a skid register; in_ready drops only while the skid
// register is occupied, so bytes that cause no result keep flowing until
// then.
module http_request_line_parser_core
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [hrlp_pkg::LEN_W-1:0] cfg_data,

    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 data_byte,
    input  logic                       first_byte,
    input  logic                       end_of_data,

    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       line_ok,
    output logic [2:0]                 error_code,
    output logic [hrlp_pkg::LEN_W-1:0] method_len,
    output logic [hrlp_pkg::LEN_W-1:0] path_bytes,
    output logic [hrlp_pkg::LEN_W-1:0] query_bytes,
    output logic                       query_present,
    output logic [3:0]                 version_major,
    output logic [3:0]                 version_minor,
    output logic [hrlp_pkg::LEN_W-1:0] line_len
);

    import hrlp_pkg::*;

    logic [LEN_W-1:0]  max_line_len_reg;

    phase_t            phase_reg,        phase_next;
    logic [LEN_W-1:0]  byte_count_reg,   byte_count_next;
    logic [LEN_W-1:0]  method_count_reg, method_count_next;
    logic [LEN_W-1:0]  path_count_reg,   path_count_next;
    logic [LEN_W-1:0]  query_count_reg,  query_count_next;
    logic              query_seen_reg,   query_seen_next;
    logic [1:0]        escape_pos_reg,   escape_pos_next;
    logic [VPOS_W-1:0] version_pos_reg,  version_pos_next;
    logic [3:0]        major_digit_reg,  major_digit_next;
    logic [3:0]        minor_digit_reg,  minor_digit_next;

    result_t           out_reg,          out_next;
    logic              out_valid_reg,    out_valid_next;
    result_t           skid_reg,         skid_next;
    logic              skid_valid_reg,   skid_valid_next;

    char_class_t       cls;
    logic              accept;
    logic              out_fire;
    logic              line_open;
    phase_t            ph;
    logic [LEN_W-1:0]  pos;
    logic [LEN_W:0]    limit;
    logic              too_long;
    err_code_t         err;
    logic              done;
    logic              emit;
    result_t           res;

    hrlp_char_class u_char_class
    (
        .char_in (data_byte),
        .cls     (cls)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;

    assign limit = ({1'b0, max_line_len_reg} < LINE_CAP) ? {1'b0, max_line_len_reg} : LINE_CAP;

    always_comb
    begin
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        method_count_next = method_count_reg;
        path_count_next   = path_count_reg;
        query_count_next  = query_count_reg;
        query_seen_next   = query_seen_reg;
        escape_pos_next   = escape_pos_reg;
        version_pos_next  = version_pos_reg;
        major_digit_next  = major_digit_reg;
        minor_digit_next  = minor_digit_reg;

        line_open = (phase_reg != PH_IDLE) && (phase_reg != PH_DONE);
        ph        = first_byte ? PH_METHOD : phase_reg;
        pos       = first_byte ? '0 : byte_count_reg;
        too_long  = ({1'b0, pos} + 1'b1) > limit;
        err       = ERR_NONE;
        done      = 1'b0;
        emit      = 1'b0;

        if (accept && first_byte)
        begin
            phase_next        = PH_METHOD;
            byte_count_next   = '0;
            method_count_next = '0;
            path_count_next   = '0;
            query_count_next  = '0;
            query_seen_next   = 1'b0;
            escape_pos_next   = ESC_IDLE;
            version_pos_next  = '0;
            major_digit_next  = '0;
            minor_digit_next  = '0;
        end

        if (accept && (first_byte || line_open))
        begin
            if (too_long)
            begin
                err = ERR_LENGTH;
            end
            else
            begin
                byte_count_next = pos + 1'b1;
                case (ph)
                    PH_METHOD:
                    begin
                        if (cls.tchar)
                            method_count_next = method_count_next + 1'b1;
                        else if (method_count_next == '0)
                            err = ERR_METHOD;
                        else if (data_byte != CH_SPACE)
                            err = ERR_SEPARATOR;
                        else
                            phase_next = PH_TSTART;
                    end
                    PH_TSTART:
                    begin
                        if (data_byte != CH_SLASH)
                        begin
                            err = ERR_TARGET;
                        end
                        else
                        begin
                            path_count_next = 12'd1;
                            phase_next      = PH_PATH;
                        end
                    end
                    PH_PATH, PH_QUERY:
                    begin
                        if (escape_pos_reg != ESC_IDLE)
                        begin
                            if (!cls.hex)
                                err = ERR_TARGET;
                            else
                                escape_pos_next = (escape_pos_reg == ESC_FIRST) ?
                                                  ESC_SECOND : ESC_IDLE;
                        end
                        else if (data_byte == CH_SPACE)
                            phase_next = PH_VERSION;
                        else if (data_byte == CH_PERCENT)
                            escape_pos_next = ESC_FIRST;
                        else if (data_byte == CH_QMARK && ph == PH_PATH)
                        begin
                            query_seen_next = 1'b1;
                            phase_next      = PH_QUERY;
                        end
                        else if (!(cls.pchar || data_byte == CH_SLASH ||
                                   data_byte == CH_QMARK))
                            err = ERR_SEPARATOR;

                        // Every target byte except the separators adds to the count.
                        if (err == ERR_NONE && data_byte != CH_SPACE &&
                            !(data_byte == CH_QMARK && ph == PH_PATH) ||
                            err == ERR_NONE && escape_pos_reg != ESC_IDLE)
                        begin
                            if (query_seen_reg)
                                query_count_next = query_count_reg + 1'b1;
                            else
                                path_count_next = path_count_reg + 1'b1;
                        end
                    end
                    PH_VERSION:
                    begin
                        if (version_pos_reg >= VPOS_END)
                            err = ERR_VERSION;
                        else if (version_pos_reg == VPOS_MAJOR ||
                                 version_pos_reg == VPOS_MINOR)
                        begin
                            if (!cls.digit)
                                err = ERR_VERSION;
                            else if (version_pos_reg == VPOS_MAJOR)
                                major_digit_next = data_byte[3:0];
                            else
                                minor_digit_next = data_byte[3:0];
                        end
                        else if (data_byte != VER_PATTERN[version_pos_reg[2:0]])
                            err = ERR_VERSION;

                        if (err == ERR_NONE)
                        begin
                            version_pos_next = version_pos_reg + 1'b1;
                            if (version_pos_next == VPOS_END)
                                phase_next = PH_CR;
                        end
                    end
                    PH_CR:
                    begin
                        if (data_byte != CH_CR)
                            err = ERR_TERMINATOR;
                        else
                            phase_next = PH_LF;
                    end
                    PH_LF:
                    begin
                        if (data_byte != CH_LF)
                            err = ERR_TERMINATOR;
                        else
                            done = 1'b1;
                    end
                    default:
                    begin
                        err = ERR_LENGTH;
                    end
                endcase
            end

            emit = (err != ERR_NONE) || done || end_of_data;
            if (emit)
                phase_next = PH_DONE;
        end

        res.ok            = done && (err == ERR_NONE);
        res.err           = (err == ERR_NONE && !done) ? ERR_LENGTH : err;
        res.method_len    = method_count_next;
        res.path_bytes    = path_count_next;
        res.query_bytes   = query_count_next;
        res.query_present = query_seen_next;
        res.major         = major_digit_next;
        res.minor         = minor_digit_next;
        res.line_len      = (err != ERR_NONE) ? pos : byte_count_next;
    end

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (emit)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_line_len_reg <= MAX_LINE_LEN_RESET;
            phase_reg        <= PH_IDLE;
            byte_count_reg   <= '0;
            method_count_reg <= '0;
            path_count_reg   <= '0;
            query_count_reg  <= '0;
            query_seen_reg   <= 1'b0;
            escape_pos_reg   <= ESC_IDLE;
            version_pos_reg  <= '0;
            major_digit_reg  <= '0;
            minor_digit_reg  <= '0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_line_len_reg <= cfg_data;
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            method_count_reg <= method_count_next;
            path_count_reg   <= path_count_next;
            query_count_reg  <= query_count_next;
            query_seen_reg   <= query_seen_next;
            escape_pos_reg   <= escape_pos_next;
            version_pos_reg  <= version_pos_next;
            major_digit_reg  <= major_digit_next;
            minor_digit_reg  <= minor_digit_next;
            out_valid_reg    <= out_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid     = out_valid_reg;
    assign line_ok       = out_reg.ok;
    assign error_code    = out_reg.err;
    assign method_len    = out_reg.method_len;
    assign path_bytes    = out_reg.path_bytes;
    assign query_bytes   = out_reg.query_bytes;
    assign query_present = out_reg.query_present;
    assign version_major = out_reg.major;
    assign version_minor = out_reg.minor;
    assign line_len      = out_reg.line_len;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid register holds a result while the output register is empty.");

    a_ok_has_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.ok) |-> (out_reg.err == ERR_NONE))
        else $error("A valid line reports an error code.");

    a_ok_has_method: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.ok) |-> (out_reg.method_len != '0 &&
                                           out_reg.path_bytes != '0))
        else $error("A valid line reports an empty method or path.");

    a_query_needs_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.query_present) |-> (out_reg.query_bytes == '0))
        else $error("Query bytes counted without a question mark.");

    a_result_closes_line: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (phase_reg == PH_DONE))
        else $error("Parser did not close the line after giving a result.");
`endif

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import hrlp_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_LINES = 30;

    typedef enum {DRAW_TCHAR, DRAW_PCHAR, DRAW_HEX} draw_kind_t;
    typedef enum {FAULT_NONE, FAULT_BAD_BYTE, FAULT_TRUNCATED, FAULT_DROPPED, FAULT_NOISE}
        line_fault_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [7:0]       data_byte = '0;
    logic             first_byte = 1'b0;
    logic             end_of_data = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic             line_ok;
    logic [2:0]       error_code;
    logic [LEN_W-1:0] method_len;
    logic [LEN_W-1:0] path_bytes;
    logic [LEN_W-1:0] query_bytes;
    logic             query_present;
    logic [3:0]       version_major;
    logic [3:0]       version_minor;
    logic [LEN_W-1:0] line_len;

    // Parser state as the checker sees it.
    phase_t           ln_phase = PH_IDLE;
    logic [LEN_W-1:0] ln_bytes = '0;
    logic [LEN_W-1:0] ln_method = '0;
    logic [LEN_W-1:0] ln_path = '0;
    logic [LEN_W-1:0] ln_query = '0;
    logic             ln_qseen = 1'b0;
    logic [1:0]       ln_esc = ESC_IDLE;
    logic [3:0]       ln_vpos = '0;
    logic [3:0]       ln_major = '0;
    logic [3:0]       ln_minor = '0;
    logic [LEN_W-1:0] max_len_cfg = MAX_LINE_LEN_RESET;

    result_t    line_verdicts[$];
    logic [7:0] line_q[$];
    int         mismatches = 0;
    int         results_seen = 0;
    int         idle_cycles = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_requests = 0;
    int         hold_seen = 0;
    int         hold_left = 0;

    http_request_line_parser_core i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .first_byte    (first_byte),
        .end_of_data   (end_of_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .line_ok       (line_ok),
        .error_code    (error_code),
        .method_len    (method_len),
        .path_bytes    (path_bytes),
        .query_bytes   (query_bytes),
        .query_present (query_present),
        .version_major (version_major),
        .version_minor (version_minor),
        .line_len      (line_len)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic is_alnum(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic logic is_tchar(logic [7:0] c);
        case (c)
            "!", "#", "$", "%", "&", "'", "*", "+", "-", ".", "^", "_", "\140", "|", "~":
                return 1'b1;
            default:
                return is_alnum(c);
        endcase
    endfunction

    function automatic logic is_pchar(logic [7:0] c);
        case (c)
            "-", ".", "_", "~", "!", "$", "&", "'", "(", ")", "*", "+", ",", ";", "=", ":",
            "@":
                return 1'b1;
            default:
                return is_alnum(c);
        endcase
    endfunction

    function automatic void open_line();
        ln_bytes  = '0;
        ln_method = '0;
        ln_path   = '0;
        ln_query  = '0;
        ln_qseen  = 1'b0;
        ln_esc    = ESC_IDLE;
        ln_vpos   = '0;
        ln_major  = '0;
        ln_minor  = '0;
    endfunction

    function automatic void close_line(logic ok, err_code_t err, logic [LEN_W-1:0] len);
        result_t r;
        r.ok            = ok;
        r.err           = err;
        r.method_len    = ln_method;
        r.path_bytes    = ln_path;
        r.query_bytes   = ln_query;
        r.query_present = ln_qseen;
        r.major         = ln_major;
        r.minor         = ln_minor;
        r.line_len      = len;
        line_verdicts.push_back(r);
        ln_phase = PH_DONE;
    endfunction

    function automatic void count_target();
        if (ln_qseen)
            ln_query = ln_query + 1'b1;
        else
            ln_path = ln_path + 1'b1;
    endfunction

    function automatic err_code_t target_char(logic [7:0] c, logic in_query);
        if (ln_esc != ESC_IDLE)
        begin
            if (!is_hex(c))
                return ERR_TARGET;
            count_target();
            ln_esc = (ln_esc == ESC_SECOND) ? ESC_IDLE : ESC_SECOND;
            return ERR_NONE;
        end
        if (c == CH_SPACE)
        begin
            ln_phase = PH_VERSION;
            return ERR_NONE;
        end
        if (c == CH_PERCENT)
        begin
            ln_esc = ESC_FIRST;
            count_target();
            return ERR_NONE;
        end
        if (is_pchar(c) || c == CH_SLASH)
        begin
            count_target();
            return ERR_NONE;
        end
        if (c == CH_QMARK)
        begin
            if (in_query)
                count_target();
            else
            begin
                ln_qseen = 1'b1;
                ln_phase = PH_QUERY;
            end
            return ERR_NONE;
        end
        return ERR_SEPARATOR;
    endfunction

    function automatic void parse_byte(logic [7:0] c, logic fb, logic eod);
        int unsigned limit;
        int unsigned pos;
        err_code_t   err;
        logic        done;
        err  = ERR_NONE;
        done = 1'b0;
        if (fb)
        begin
            open_line();
            ln_phase = PH_METHOD;
        end
        else if (ln_phase == PH_IDLE || ln_phase == PH_DONE)
            return;
        limit = (max_len_cfg < LINE_MAX) ? max_len_cfg : LINE_MAX;
        pos = ln_bytes;
        if (pos + 1 > limit)
        begin
            close_line(1'b0, ERR_LENGTH, LEN_W'(pos));
            return;
        end
        ln_bytes = LEN_W'(pos + 1);
        case (ln_phase)
            PH_METHOD:
                if (is_tchar(c))
                    ln_method = ln_method + 1'b1;
                else if (ln_method == 0)
                    err = ERR_METHOD;
                else if (c != CH_SPACE)
                    err = ERR_SEPARATOR;
                else
                    ln_phase = PH_TSTART;
            PH_TSTART:
                if (c != CH_SLASH)
                    err = ERR_TARGET;
                else
                begin
                    ln_path  = 12'd1;
                    ln_phase = PH_PATH;
                end
            PH_PATH:
                err = target_char(c, 1'b0);
            PH_QUERY:
                err = target_char(c, 1'b1);
            PH_VERSION:
            begin
                if (ln_vpos == VPOS_MAJOR || ln_vpos == VPOS_MINOR)
                begin
                    if (c < "0" || c > "9")
                        err = ERR_VERSION;
                    else if (ln_vpos == VPOS_MAJOR)
                        ln_major = 4'(c - "0");
                    else
                        ln_minor = 4'(c - "0");
                end
                else if (c != VER_PATTERN[ln_vpos])
                    err = ERR_VERSION;
                if (err == ERR_NONE)
                begin
                    ln_vpos = ln_vpos + 1'b1;
                    if (ln_vpos == VPOS_END)
                        ln_phase = PH_CR;
                end
            end
            PH_CR:
                if (c != CH_CR)
                    err = ERR_TERMINATOR;
                else
                    ln_phase = PH_LF;
            PH_LF:
                if (c != CH_LF)
                    err = ERR_TERMINATOR;
                else
                    done = 1'b1;
            default:
                err = ERR_LENGTH;
        endcase
        if (err != ERR_NONE)
            close_line(1'b0, err, LEN_W'(pos));
        else if (done)
            close_line(1'b1, ERR_NONE, ln_bytes);
        else if (eod)
            close_line(1'b0, ERR_LENGTH, ln_bytes);
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatches < REPORT_LINES)
            $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [11:0] want,
                               input logic [11:0] got);
        if (got !== want)
            flag_mismatch($sformatf("result %0d %s expected %0d got %0d",
                                    results_seen, name, want, got));
    endtask

    task automatic check_line_result();
        result_t want;
        if (line_verdicts.size() == 0)
            flag_mismatch($sformatf("result %0d arrived with no line pending", results_seen));
        else
        begin
            want = line_verdicts.pop_front();
            check_field("line_ok", 12'(want.ok), 12'(line_ok));
            check_field("error_code", 12'(want.err), 12'(error_code));
            check_field("method_len", want.method_len, method_len);
            check_field("path_bytes", want.path_bytes, path_bytes);
            check_field("query_bytes", want.query_bytes, query_bytes);
            check_field("query_present", 12'(want.query_present), 12'(query_present));
            check_field("version_major", 12'(want.major), 12'(version_major));
            check_field("version_minor", 12'(want.minor), 12'(version_minor));
            check_field("line_len", want.line_len, line_len);
        end
        results_seen++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_line_result();
            if (cfg_valid && cfg_ready)
                max_len_cfg = cfg_data;
            if (in_valid && in_ready)
                parse_byte(data_byte, first_byte, end_of_data);
            if ((out_valid && out_ready) || (cfg_valid && cfg_ready) || (in_valid && in_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fb, input logic eod);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        data_byte   <= b;
        first_byte  <= fb;
        end_of_data <= eod;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_line(input int count, input int eod_at);
        int i;
        for (i = 0; i < count; i++)
            send_byte(line_q[i], i == 0, i == eod_at);
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (line_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_len(input logic [LEN_W-1:0] value);
        wait_results_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] draw_char(draw_kind_t kind);
        logic [7:0] c;
        c = 8'($urandom_range(33, 126));
        while (!(kind == DRAW_TCHAR ? is_tchar(c) : kind == DRAW_PCHAR ? is_pchar(c) : is_hex(c)))
            c = 8'($urandom_range(33, 126));
        return c;
    endfunction

    function automatic void push_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endfunction

    function automatic void push_escape();
        line_q.push_back(CH_PERCENT);
        line_q.push_back(draw_char(DRAW_HEX));
        line_q.push_back(draw_char(DRAW_HEX));
    endfunction

    function automatic void make_line();
        int n;
        int i;
        line_q.delete();
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 6);
        for (i = 0; i < n; i++)
            line_q.push_back(draw_char(DRAW_TCHAR));
        line_q.push_back(CH_SPACE);
        line_q.push_back(CH_SLASH);
        n = $urandom_range(0, 6);
        for (i = 0; i < n; i++)
            case ($urandom_range(0, 7))
                0: line_q.push_back(CH_SLASH);
                1: push_escape();
                default: line_q.push_back(draw_char(DRAW_PCHAR));
            endcase
        if ($urandom_range(0, 1) == 1)
        begin
            line_q.push_back(CH_QMARK);
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++)
                case ($urandom_range(0, 7))
                    0: line_q.push_back(CH_SLASH);
                    1: line_q.push_back(CH_QMARK);
                    2: push_escape();
                    default: line_q.push_back(draw_char(DRAW_PCHAR));
                endcase
        end
        push_text(" HTTP/");
        line_q.push_back(8'("0" + $urandom_range(0, 9)));
        push_text(".");
        line_q.push_back(8'("0" + $urandom_range(0, 9)));
        line_q.push_back(CH_CR);
        line_q.push_back(CH_LF);
    endfunction

    task automatic send_text(input string s, input bit with_crlf, input bit eod_last);
        line_q.delete();
        push_text(s);
        if (with_crlf)
        begin
            line_q.push_back(CH_CR);
            line_q.push_back(CH_LF);
        end
        send_line(line_q.size(), eod_last ? line_q.size() - 1 : -1);
    endtask

    task automatic test_special_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_byte("x", 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b1);
        send_text(" ", 1'b0, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b0);
        send_text("G\011", 1'b0, 1'b0);
        send_text("G x", 1'b0, 1'b0);
        send_text("G /%4g", 1'b0, 1'b0);
        send_text("G /<", 1'b0, 1'b0);
        send_text("G / HTTP/1.x", 1'b0, 1'b0);
        send_text("G / HTTP/1.1\012", 1'b0, 1'b0);
        send_text("G /%7e?q/? HTTP/0.9", 1'b1, 1'b0);
        send_byte("a", 1'b0, 1'b0);
        send_text("G /a", 1'b0, 1'b1);
        wait_results_drained();
    endtask

    task automatic test_length_limits();
        int i;
        write_max_len(12'd16);
        send_text("GET / HTTP/1.1", 1'b1, 1'b0);
        send_text("GETX / HTTP/1.1", 1'b1, 1'b0);
        write_max_len(12'd40);
        for (i = 0; i <= 40; i++)
            send_byte(draw_char(DRAW_TCHAR), i == 0, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [LEN_W-1:0] limit, input int n_bytes);
        int          sent;
        int          cut;
        int          roll;
        line_fault_t fault;
        write_max_len(limit);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_bytes)
        begin
            make_line();
            roll  = $urandom_range(0, 9);
            fault = (roll < 6) ? FAULT_NONE : line_fault_t'(roll - 5);
            cut   = $urandom_range(1, line_q.size() - 1);
            case (fault)
                FAULT_BAD_BYTE:
                begin
                    line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
                    send_line(line_q.size(), -1);
                    sent += line_q.size();
                end
                FAULT_TRUNCATED:
                begin
                    send_line(cut, cut - 1);
                    sent += cut;
                end
                FAULT_DROPPED:
                begin
                    send_line(cut, -1);
                    sent += cut;
                end
                FAULT_NOISE:
                begin
                    repeat ($urandom_range(1, 4))
                        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
                    send_line(line_q.size(), -1);
                    sent += line_q.size();
                end
                default:
                begin
                    send_line(line_q.size(),
                              ($urandom_range(0, 7) == 0) ? line_q.size() - 1 : -1);
                    sent += line_q.size();
                end
            endcase
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
        end
        wait_results_drained();
    endtask

    task automatic test_backpressure_hold();
        write_max_len(12'd4095);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        repeat (40)
            send_byte(CH_SPACE, 1'b1, 1'b0);
        make_line();
        send_line(line_q.size(), -1);
        wait_results_drained();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_special_cases();
        test_length_limits();
        test_random_traffic(0, 0, 12'd4095, 140);
        test_random_traffic(46, 0, 12'd40, 140);
        test_random_traffic(0, 46, 12'($urandom_range(16, 4095)), 140);
        test_random_traffic(36, 36, 12'd16, 140);
        test_backpressure_hold();
        wait_results_drained();
        repeat (8) @(posedge clk);
        if (line_verdicts.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", line_verdicts.size()));
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: files.f
sv/hrlp_pkg.sv
sv/hrlp_char_class.sv
sv/http_request_line_parser_core.sv
tb/sv/tb.sv
